// ----- rtl/sdrr_pkg.sv -----
package sdrr_pkg;

  localparam int unsigned Sets     = 2048;
  localparam int unsigned Ways     = 16;
  localparam int unsigned SigBits  = 6;
  localparam int unsigned Leaders  = 64;
  localparam int unsigned SetW     = $clog2(Sets);
  localparam int unsigned WayW     = $clog2(Ways);
  localparam int unsigned SigCount = 1 << SigBits;
  localparam int unsigned Stride   = (Sets / (2 * Leaders)) == 0 ? 1 : Sets / (2 * Leaders);
  localparam int unsigned Half     = Sets / 2;

  localparam logic [9:0] SelMax   = 10'd1023;
  localparam logic [9:0] SelReset = 10'd512;

  // configuration register indexes
  localparam logic [1:0] RegDecay  = 2'd0;
  localparam logic [1:0] RegDead   = 2'd1;
  localparam logic [1:0] RegReuse  = 2'd2;
  localparam logic [1:0] RegSplit  = 2'd3;

  // commands
  localparam logic CmdQuery  = 1'b0;
  localparam logic CmdUpdate = 1'b1;

  // one set row of line state
  typedef struct packed {
    logic [Ways-1:0][1:0]         rrpv;
    logic [Ways-1:0][SigBits-1:0] sig;
    logic [Ways-1:0]              reuse;
  } row_t;

  typedef struct packed {
    logic [19:0] decay_interval;
    logic [4:0]  dead_limit;
    logic [1:0]  reuse_high;
    logic [9:0]  selector_split;
  } cfg_t;

  // 0 follower, 1 LIP leader, 2 BIP leader
  function automatic logic [1:0] leader_kind(input logic [SetW-1:0] set);
    logic [SetW-1:0] off;
    logic [1:0] k;
    k = 2'd0;
    if (set < SetW'(Half)) begin
      if ((set % SetW'(Stride)) == '0 && (set / SetW'(Stride)) < SetW'(Leaders)) k = 2'd1;
    end else begin
      off = set - SetW'(Half);
      if ((off % SetW'(Stride)) == '0 && (off / SetW'(Stride)) < SetW'(Leaders)) k = 2'd2;
    end
    return k;
  endfunction

endpackage

// ----- rtl/sdrr_sig_table.sv -----
module sdrr_sig_table (
  input  logic                         clk_i,
  input  logic [sdrr_pkg::SigBits-1:0] rd_sig_i,
  output logic [1:0]                   rd_cnt_o,
  input  logic                         wr_en_i,
  input  logic [sdrr_pkg::SigBits-1:0] wr_sig_i,
  input  logic [1:0]                   wr_cnt_i
);
  import sdrr_pkg::*;

  // signature counters, one read and one write a cycle
  logic [1:0] cnt_mem [SigCount];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) cnt_mem[wr_sig_i] <= wr_cnt_i;
    rd_cnt_o <= cnt_mem[rd_sig_i];
  end

endmodule

// ----- rtl/sdrr_row_mem.sv -----
module sdrr_row_mem (
  input  logic                     clk_i,
  input  logic [sdrr_pkg::SetW-1:0] rd_addr_i,
  output sdrr_pkg::row_t           rd_data_o,
  input  logic                     wr_en_i,
  input  logic [sdrr_pkg::SetW-1:0] wr_addr_i,
  input  sdrr_pkg::row_t           wr_data_i
);
  import sdrr_pkg::*;

  row_t mem [Sets];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) mem[wr_addr_i] <= wr_data_i;
    rd_data_o <= mem[rd_addr_i];
  end

endmodule

// ----- rtl/ship_dip_rrip_replacement.sv -----
// Flow: the input beat's row is read, then modified and written back as the result is
// registered. No new item is taken before the last result beat has left; an update that
// reaches the decay interval adds a sweep that clears reuse bits and decays signature
// counters, one entry a cycle. Reset: asynchronous active low; a sweep then initialises
// the rows and sets counters to 1 before items are accepted; config writes are taken meanwhile.
module ship_dip_rrip_replacement (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        cmd_i,
  input  logic [10:0] set_index_i,
  input  logic [3:0]  way_i,
  input  logic [15:0] valid_mask_i,
  input  logic [7:0]  pc_low_i,
  input  logic        hit_i,
  input  logic [4:0]  rand_draw_i,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [3:0]  victim_way_o,
  output logic [1:0]  filled_rrpv_o,
  output logic [9:0]  selector_value_o,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index_i,
  input  logic [19:0] cfg_data_i
);
  import sdrr_pkg::*;

  localparam logic [2:0] StClear = 3'd0;
  localparam logic [2:0] StIdle  = 3'd1;
  localparam logic [2:0] StRead  = 3'd2;
  localparam logic [2:0] StOut   = 3'd3;
  localparam logic [2:0] StSweep = 3'd4;

  logic [2:0]      state_q, state_d;
  logic [SetW:0]   clr_q;
  logic [SetW:0]   sweep_prev;
  cfg_t            cfg_q;
  logic [9:0]      sel_q, sel_d;
  logic [19:0]     ucnt_q;
  logic            decay_q;

  // latched item
  logic            cmd_q, hit_q;
  logic [SetW-1:0] set_q;
  logic [WayW-1:0] way_q;
  logic [Ways-1:0] vmask_q;
  logic [SigBits-1:0] sig_q;
  logic [SigBits-1:0] old_sig_q;
  logic [4:0]      draw_q;

  logic [3:0]      vict_q;
  logic [1:0]      fill_q;
  logic            oval_q;

  row_t            rd_row, wr_row;
  logic            wr_en;
  logic [SetW-1:0] wr_addr, rd_addr;

  logic               ctr_we;
  logic [SigBits-1:0] ctr_raddr, ctr_waddr;
  logic [1:0]         ctr_wdata;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state_q != StIdle) || oval_q;
  assign out_valid = oval_q;
  assign victim_way_o     = vict_q;
  assign filled_rrpv_o    = fill_q;
  assign selector_value_o = sel_q;

  logic accept;
  assign accept = in_valid && !in_stall;
  // the decay sweep reads one row ahead of the row it writes
  assign sweep_prev = clr_q - 1'b1;
  assign rd_addr = (state_q == StSweep) ? clr_q[SetW-1:0] : set_index_i;

  sdrr_row_mem u_mem (
    .clk_i    (clk_i),
    .rd_addr_i(rd_addr),
    .rd_data_o(rd_row),
    .wr_en_i  (wr_en),
    .wr_addr_i(wr_addr),
    .wr_data_i(wr_row)
  );

  // modify stage
  logic [SigBits-1:0] old_sig;
  logic [1:0]  cur_cnt, kind, top;
  logic        lip, decay, upd;
  logic [4:0]  unused;
  logic [1:0]  result;
  logic [3:0]  victim;
  logic        found;
  logic [19:0] ucnt_inc;
  row_t        mod_row;

  assign upd     = (state_q == StRead) && cmd_q == CmdUpdate;
  assign old_sig = rd_row.sig[way_q];
  assign kind    = leader_kind(set_q);
  assign ucnt_inc = ucnt_q + 20'd1;
  assign decay   = upd && (ucnt_inc >= cfg_q.decay_interval);

  // cur_cnt holds the counter of the new signature in StRead, of the old one in StOut
  sdrr_sig_table u_sig (
    .clk_i   (clk_i),
    .rd_sig_i(ctr_raddr),
    .rd_cnt_o(cur_cnt),
    .wr_en_i (ctr_we),
    .wr_sig_i(ctr_waddr),
    .wr_cnt_i(ctr_wdata)
  );

  // counter table port: clearing, hit training, miss training, decay sweep
  always_comb begin
    ctr_we    = 1'b0;
    ctr_waddr = sig_q;
    ctr_wdata = cur_cnt;
    ctr_raddr = pc_low_i[SigBits+1:2];
    unique case (state_q)
      StClear: begin
        ctr_we    = clr_q < (SetW+1)'(SigCount);
        ctr_waddr = clr_q[SigBits-1:0];
        ctr_wdata = 2'd1;
      end
      StRead: begin
        ctr_raddr = old_sig;
        ctr_we    = upd && hit_q;
        ctr_waddr = sig_q;
        ctr_wdata = (cur_cnt != 2'd3) ? cur_cnt + 2'd1 : cur_cnt;
      end
      StOut: begin
        ctr_we    = cmd_q == CmdUpdate && !hit_q;
        ctr_waddr = old_sig_q;
        ctr_wdata = (cur_cnt != 2'd0) ? cur_cnt - 2'd1 : cur_cnt;
      end
      StSweep: begin
        ctr_raddr = clr_q[SigBits-1:0];
        ctr_we    = clr_q != '0 && clr_q <= (SetW+1)'(SigCount);
        ctr_waddr = sweep_prev[SigBits-1:0];
        ctr_wdata = (cur_cnt != 2'd0) ? cur_cnt - 2'd1 : cur_cnt;
      end
      default: ;
    endcase
  end

  always_comb begin
    mod_row = rd_row;
    victim  = '0;
    found   = 1'b0;
    result  = 2'd0;
    sel_d   = sel_q;
    unused  = '0;
    lip     = 1'b0;
    top     = 2'd0;
    if (cmd_q == CmdQuery) begin
      for (int w = Ways - 1; w >= 0; w--) begin
        if (!vmask_q[w]) begin
          victim = 4'(w);
          found  = 1'b1;
        end
      end
      if (!found) begin
        for (int w = 0; w < Ways; w++) begin
          if (rd_row.rrpv[w] > top) top = rd_row.rrpv[w];
        end
        for (int w = 0; w < Ways; w++) begin
          mod_row.rrpv[w] = rd_row.rrpv[w] + (2'd3 - top);
        end
        for (int w = Ways - 1; w >= 0; w--) begin
          if (mod_row.rrpv[w] == 2'd3) victim = 4'(w);
        end
      end
    end else begin
      // the reused-bit count sees this line's bit already cleared on a miss
      mod_row.reuse[way_q] = hit_q;
      for (int w = 0; w < Ways; w++) unused = unused + 5'(!mod_row.reuse[w]);
      if (!hit_q) begin
        unique case (kind)
          2'd1:    lip = 1'b1;
          2'd2:    lip = 1'b0;
          default: lip = sel_q < cfg_q.selector_split;
        endcase
        if (unused > cfg_q.dead_limit) lip = 1'b1;
        result = 2'd3;
        if (!lip && draw_q == 5'd0) result = 2'd0;
        // counter after this miss's decrement of the old signature
        if (((old_sig == sig_q && cur_cnt != 2'd0) ? cur_cnt - 2'd1 : cur_cnt)
            >= cfg_q.reuse_high) result = 2'd0;
        if (kind == 2'd1 && sel_q < SelMax) sel_d = sel_q + 10'd1;
        else if (kind == 2'd2 && sel_q > 10'd0) sel_d = sel_q - 10'd1;
      end
      mod_row.rrpv[way_q] = result;
      mod_row.sig[way_q]  = sig_q;
    end
  end

  // write port: clearing sweep, write-back or decay sweep
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = set_q;
    wr_row  = mod_row;
    if (state_q == StClear) begin
      wr_en   = 1'b1;
      wr_addr = clr_q[SetW-1:0];
      for (int w = 0; w < Ways; w++) begin
        wr_row.rrpv[w] = 2'd3;
        wr_row.sig[w]  = '0;
        wr_row.reuse[w] = 1'b0;
      end
    end else if (state_q == StRead) begin
      wr_en = 1'b1;
    end else if (state_q == StSweep) begin
      wr_en   = clr_q != '0;
      wr_addr = sweep_prev[SetW-1:0];
      wr_row  = rd_row;
      wr_row.reuse = '0;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StClear: if (clr_q == (SetW+1)'(Sets - 1)) state_d = StIdle;
      StIdle:  if (accept) state_d = StRead;
      StRead:  state_d = StOut;
      StOut:   state_d = decay_q ? StSweep : StIdle;
      StSweep: if (clr_q == (SetW+1)'(Sets)) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StClear;
      clr_q   <= '0;
      cfg_q   <= '{decay_interval: 20'd100000, dead_limit: 5'd12,
                   reuse_high: 2'd2, selector_split: 10'd512};
      sel_q   <= SelReset;
      ucnt_q  <= '0;
      decay_q <= 1'b0;
      oval_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      // one counter walks both sweeps
      if (state_q == StClear || state_q == StSweep) clr_q <= clr_q + 1'b1;
      else clr_q <= '0;
      if (cfg_valid) begin
        unique case (cfg_index_i)
          RegDecay: cfg_q.decay_interval <= cfg_data_i;
          RegDead:  cfg_q.dead_limit     <= cfg_data_i[4:0];
          RegReuse: cfg_q.reuse_high     <= cfg_data_i[1:0];
          RegSplit: cfg_q.selector_split <= cfg_data_i[9:0];
          default:  ;
        endcase
      end
      if (state_q == StRead) begin
        sel_q   <= sel_d;
        oval_q  <= 1'b1;
        decay_q <= decay;
        if (upd) begin
          ucnt_q <= decay ? 20'd0 : ucnt_inc;
        end
      end else if (oval_q && !out_stall) begin
        oval_q <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q   <= cmd_i;
      hit_q   <= hit_i;
      set_q   <= set_index_i;
      way_q   <= way_i;
      vmask_q <= valid_mask_i;
      sig_q   <= pc_low_i[SigBits+1:2];
      draw_q  <= rand_draw_i;
    end
    if (state_q == StRead) begin
      old_sig_q <= old_sig;
      vict_q <= (cmd_q == CmdQuery) ? victim : 4'd0;
      fill_q <= (cmd_q == CmdQuery) ? 2'd0 : result;
    end
  end

endmodule

// ----- verif/ship_dip_rrip_replacement_checker.sv -----
module ship_dip_rrip_replacement_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic        cmd_i,
  input  logic [10:0] set_index_i,
  input  logic [3:0]  way_i,
  input  logic [15:0] valid_mask_i,
  input  logic [7:0]  pc_low_i,
  input  logic        hit_i,
  input  logic [4:0]  rand_draw_i,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [3:0]  victim_way_o,
  input  logic [1:0]  filled_rrpv_o,
  input  logic [9:0]  selector_value_o,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [1:0]  cfg_index_i,
  input  logic [19:0] cfg_data_i,
  output int          fail_count_o,
  output int          pending_o
);
  import sdrr_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [3:0] victim;
    logic [1:0] filled;
    logic [9:0] selector;
  } access_result_t;

  // per-line state of the whole cache
  logic [1:0]         line_rrpv  [Sets*Ways];
  logic [SigBits-1:0] line_pc_sig [Sets*Ways];
  logic               line_reuse [Sets*Ways];
  int unsigned        reuse_era  [Sets*Ways];
  logic [1:0]         sig_ctr    [SigCount];
  logic [9:0]         selector;
  logic [19:0]        updates_since_decay;
  int unsigned        decay_era;
  cfg_t               cfg;

  access_result_t result_queue[$];

  // reuse bit counts only if set during the current decay era
  function automatic logic reused(int unsigned line);
    return line_reuse[line] && reuse_era[line] == decay_era;
  endfunction

  function automatic access_result_t predict_access(logic cmd, logic [10:0] set,
      logic [3:0] way, logic [15:0] mask, logic [7:0] pc, logic hit, logic [4:0] draw);
    access_result_t r;
    int unsigned base, line, unused;
    logic [1:0] top, fill;
    logic [SigBits-1:0] sig, old;
    logic is_lip_lead, is_bip_lead, lip, found;
    r = '0;
    base = set * Ways;
    if (cmd == CmdQuery) begin
      found = 1'b0;
      for (int w = 0; w < Ways; w++)
        if (!found && !mask[w]) begin
          r.victim = 4'(w);
          found = 1'b1;
        end
      if (!found) begin
        // age the set until some way reaches distant re-reference
        top = 2'd0;
        for (int w = 0; w < Ways; w++)
          if (line_rrpv[base+w] > top) top = line_rrpv[base+w];
        for (int w = 0; w < Ways; w++)
          line_rrpv[base+w] = line_rrpv[base+w] + (2'd3 - top);
        for (int w = 0; w < Ways; w++)
          if (!found && line_rrpv[base+w] == 2'd3) begin
            r.victim = 4'(w);
            found = 1'b1;
          end
      end
    end else begin
      line = base + way;
      sig = pc[SigBits+1:2];
      is_lip_lead = set < Half && set % Stride == 0 && set / Stride < Leaders;
      is_bip_lead = set >= Half && (set - Half) % Stride == 0
                    && (set - Half) / Stride < Leaders;
      if (hit) begin
        if (sig_ctr[sig] < 2'd3) sig_ctr[sig]++;
        line_reuse[line] = 1'b1;
        reuse_era[line] = decay_era;
        fill = 2'd0;
      end else begin
        old = line_pc_sig[line];
        if (sig_ctr[old] > 2'd0) sig_ctr[old]--;
        line_reuse[line] = 1'b0;
        if (is_lip_lead) lip = 1'b1;
        else if (is_bip_lead) lip = 1'b0;
        else lip = selector < cfg.selector_split;
        unused = 0;
        for (int w = 0; w < Ways; w++)
          if (!reused(base + w)) unused++;
        if (unused > cfg.dead_limit) lip = 1'b1;
        fill = 2'd3;
        if (!lip && draw == 5'd0) fill = 2'd0;
        if (sig_ctr[sig] >= cfg.reuse_high) fill = 2'd0;
        // leader misses steer the duel
        if (is_lip_lead && selector < SelMax) selector++;
        else if (is_bip_lead && selector > 10'd0) selector--;
      end
      line_rrpv[line] = fill;
      line_pc_sig[line] = sig;
      r.filled = fill;
      updates_since_decay = updates_since_decay + 20'd1;
      if (updates_since_decay >= cfg.decay_interval) begin
        updates_since_decay = '0;
        for (int s = 0; s < SigCount; s++)
          if (sig_ctr[s] > 2'd0) sig_ctr[s]--;
        decay_era++;
      end
    end
    r.selector = selector;
    return r;
  endfunction

  task automatic report(string what, int expd, int got);
    $display("%0t mismatch %s: expected %0d got %0d", $realtime, what, expd, got);
    fail_count_o++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    access_result_t e;
    if (!rst_ni) begin
      for (int i = 0; i < Sets*Ways; i++) begin
        line_rrpv[i] = 2'd3;
        line_pc_sig[i] = '0;
        line_reuse[i] = 1'b0;
        reuse_era[i] = 0;
      end
      for (int s = 0; s < SigCount; s++) sig_ctr[s] = 2'd1;
      selector = SelReset;
      updates_since_decay = '0;
      decay_era = 0;
      cfg.decay_interval = 20'd100000;
      cfg.dead_limit = 5'd12;
      cfg.reuse_high = 2'd2;
      cfg.selector_split = 10'd512;
      result_queue.delete();
      fail_count_o = 0;
      pending_o = 0;
    end else begin
      // register writes
      if (cfg_valid && cfg_ready)
        case (cfg_index_i)
          RegDecay: cfg.decay_interval = cfg_data_i;
          RegDead:  cfg.dead_limit = cfg_data_i[4:0];
          RegReuse: cfg.reuse_high = cfg_data_i[1:0];
          RegSplit: cfg.selector_split = cfg_data_i[9:0];
          default: ;
        endcase
      // compare result beat with oldest expectation
      if (out_valid && !out_stall) begin
        if (result_queue.size() == 0) begin
          report("result beats pending", 0, 1);
        end else begin
          e = result_queue.pop_front();
          if (victim_way_o !== e.victim)
            report("victim_way", int'(e.victim), int'(victim_way_o));
          if (filled_rrpv_o !== e.filled)
            report("filled_rrpv", int'(e.filled), int'(filled_rrpv_o));
          if (selector_value_o !== e.selector)
            report("selector_value", int'(e.selector), int'(selector_value_o));
        end
      end
      // predict accepted input beat
      if (in_valid && !in_stall)
        result_queue.push_back(predict_access(cmd_i, set_index_i, way_i, valid_mask_i,
                                              pc_low_i, hit_i, rand_draw_i));
      pending_o = result_queue.size();
    end
  end

endmodule

// ----- verif/tb.sv -----
module tb;
  import sdrr_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int StallLimit = 20000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        cmd_i = 1'b0;
  logic [10:0] set_index_i = '0;
  logic [3:0]  way_i = '0;
  logic [15:0] valid_mask_i = '0;
  logic [7:0]  pc_low_i = '0;
  logic        hit_i = 1'b0;
  logic [4:0]  rand_draw_i = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [3:0]  victim_way_o;
  logic [1:0]  filled_rrpv_o;
  logic [9:0]  selector_value_o;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index_i = '0;
  logic [19:0] cfg_data_i = '0;
  int          fail_count;
  int          pending;
  int          gap_pct = 0;
  int          stall_pct = 0;
  int          quiet_cycles = 0;

  // a few hot sets: leaders of both kinds and followers
  logic [10:0] hot_sets[8] = '{11'd0, 11'd16, 11'd1008, 11'd1024, 11'd1040, 11'd5,
                               11'd700, 11'd2047};

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  ship_dip_rrip_replacement u_top (.*);

  ship_dip_rrip_replacement_checker u_checker (
    .*, .fail_count_o(fail_count), .pending_o(pending));

  // receiver backpressure
  always @(negedge clk_i) out_stall = ($urandom_range(99) < stall_pct);

  // watchdog on lack of progress
  always @(posedge clk_i) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= StallLimit) begin
      $display("ship_dip_rrip_replacement verification failed");
      $finish;
    end
  end

  task automatic write_reg(logic [1:0] idx, logic [19:0] data);
    @(negedge clk_i);
    cfg_valid = 1'b1;
    cfg_index_i = idx;
    cfg_data_i = data;
    forever begin
      @(posedge clk_i);
      if (cfg_ready) break;
    end
    @(negedge clk_i);
    cfg_valid = 1'b0;
  endtask

  task automatic send_access(logic cmd, logic [10:0] set, logic [3:0] way,
      logic [15:0] mask, logic [7:0] pc, logic hit, logic [4:0] draw);
    @(negedge clk_i);
    while ($urandom_range(99) < gap_pct) begin
      in_valid = 1'b0;
      @(negedge clk_i);
    end
    in_valid = 1'b1;
    cmd_i = cmd;
    set_index_i = set;
    way_i = way;
    valid_mask_i = mask;
    pc_low_i = pc;
    hit_i = hit;
    rand_draw_i = draw;
    forever begin
      @(posedge clk_i);
      if (!in_stall) break;
    end
  endtask

  task automatic drain();
    @(negedge clk_i);
    in_valid = 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  // mostly traffic on hot sets with a small pc pool, some full-range noise
  task automatic random_access();
    logic [10:0] set;
    logic [7:0] pc;
    logic [15:0] mask;
    if ($urandom_range(99) < 25) begin
      set = 11'($urandom_range(2047));
      pc = 8'($urandom_range(255));
    end else begin
      set = hot_sets[$urandom_range(7)];
      pc = 8'($urandom_range(3) << (2 + 4 * $urandom_range(1)));
      pc = pc | 8'($urandom_range(3));
    end
    mask = ($urandom_range(99) < 75) ? 16'hFFFF : 16'($urandom_range(65535));
    send_access(($urandom_range(99) < 35) ? CmdQuery : CmdUpdate, set,
                4'($urandom_range(15)), mask, pc, 1'($urandom_range(1)),
                ($urandom_range(3) == 0) ? 5'd0 : 5'($urandom_range(31)));
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    // registers go in during the clearing sweep
    write_reg(RegDecay, 20'd100000);
    write_reg(RegDead, 20'd12);
    write_reg(RegReuse, 20'd2);
    write_reg(RegSplit, 20'd512);

    // directed: masks, aging, leaders, followers, field extremes
    send_access(CmdQuery, 11'd0, 4'd0, 16'h0000, 8'h00, 1'b0, 5'd0);
    send_access(CmdQuery, 11'd2047, 4'd15, 16'h7FFF, 8'hFF, 1'b1, 5'd31);
    send_access(CmdQuery, 11'd3, 4'd0, 16'hFFFF, 8'h00, 1'b0, 5'd0);
    send_access(CmdUpdate, 11'd0, 4'd0, 16'h0000, 8'h00, 1'b0, 5'd0);
    send_access(CmdUpdate, 11'd1024, 4'd1, 16'hFFFF, 8'h04, 1'b0, 5'd0);
    send_access(CmdUpdate, 11'd1024, 4'd2, 16'hFFFF, 8'h08, 1'b0, 5'd31);
    send_access(CmdUpdate, 11'd5, 4'd15, 16'hFFFF, 8'hFF, 1'b1, 5'd31);
    send_access(CmdUpdate, 11'd5, 4'd15, 16'hFFFF, 8'hFF, 1'b1, 5'd0);
    send_access(CmdUpdate, 11'd5, 4'd14, 16'hFFFF, 8'hFC, 1'b0, 5'd0);
    send_access(CmdUpdate, 11'd5, 4'd15, 16'hFFFF, 8'h00, 1'b0, 5'd0);
    send_access(CmdQuery, 11'd5, 4'd0, 16'hFFFF, 8'h00, 1'b0, 5'd0);
    send_access(CmdQuery, 11'd5, 4'd0, 16'hFFFE, 8'h00, 1'b0, 5'd0);
    send_access(CmdUpdate, 11'd2047, 4'd15, 16'hFFFF, 8'hFF, 1'b0, 5'd31);
    send_access(CmdUpdate, 11'd1008, 4'd3, 16'hFFFF, 8'h55, 1'b0, 5'd1);
    send_access(CmdUpdate, 11'd1040, 4'd3, 16'hFFFF, 8'hAA, 1'b0, 5'd0);
    send_access(CmdQuery, 11'd1040, 4'd0, 16'hFFFF, 8'hAA, 1'b0, 5'd0);
    drain();

    // phases of settings, each running through the same idling mixes
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          write_reg(RegDecay, 20'd1);
          write_reg(RegDead, 20'd0);
          write_reg(RegReuse, 20'd0);
          write_reg(RegSplit, 20'd0);
        end
        1: begin
          write_reg(RegDecay, 20'hFFFFF);
          write_reg(RegDead, 20'd16);
          write_reg(RegReuse, 20'd3);
          write_reg(RegSplit, 20'd1023);
        end
        2: begin
          write_reg(RegDecay, 20'd7);
          write_reg(RegDead, 20'd16);
          write_reg(RegReuse, 20'd2);
          write_reg(RegSplit, 20'd512);
        end
        default: begin
          write_reg(RegDecay, 20'd0);
          write_reg(RegDead, 20'($urandom_range(16)));
          write_reg(RegReuse, 20'($urandom_range(3)));
          write_reg(RegSplit, 20'($urandom_range(1023)));
        end
      endcase
      for (int i = 0; i < 163; i++) begin
        if (i == 0) begin
          gap_pct = 9;
          stall_pct = 53;
        end else if (i == 55) begin
          gap_pct = 53;
          stall_pct = 9;
        end else if (i == 110) begin
          gap_pct = 0;
          stall_pct = 0;
        end
        // hold off until all results are back
        if (i == 80) drain();
        random_access();
      end
      drain();
    end

    if (fail_count == 0)
      $display("ship_dip_rrip_replacement verification clean");
    else
      $display("ship_dip_rrip_replacement verification failed");
    $finish;
  end

endmodule
